### design/angular_range_rw_lock_arbiter_unit_defines.svh
// Assertion macros shared by the lock arbiter files.
`ifndef ANGULAR_RANGE_RW_LOCK_ARBITER_UNIT_DEFINES_SVH
`define ANGULAR_RANGE_RW_LOCK_ARBITER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define ARLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ARLA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/arla_pkg.sv
package arla_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned FullCircle = 360;
  localparam int unsigned SlotW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned DegW = 9;

  typedef enum logic [2:0] {
    OP_SET_ROT   = 3'd0,
    OP_LOCK_RD   = 3'd1,
    OP_LOCK_WR   = 3'd2,
    OP_UNLOCK_RD = 3'd3,
    OP_UNLOCK_WR = 3'd4,
    OP_EXIT      = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HT_EMPTY = 2'd0,
    HT_READ  = 2'd1,
    HT_WRITE = 2'd2
  } held_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EXIT_W,
    S_EXIT_H,
    S_HELD,
    S_WAIT,
    S_EMIT_GRANT,
    S_EMIT_STATUS
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the input transaction
    logic apply;      // apply the operation to the slot table and status
    logic exit_w_clr; // clear index for the exit waiter walk
    logic exit_w_step;
    logic exit_h_step;
    logic held_clr;
    logic held_step;
    logic wait_step;  // evaluate the waiter at the scan index
    logic out_grant;
    logic out_status;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic do_scan;     // operation calls for a scan
    logic exit_w_done;
    logic exit_h_done;
    logic held_done;
    logic wait_done;
    logic grant_now;   // current waiter granted
  } stat_t;

  function automatic logic covers(input logic [DegW-1:0] rot,
                                  input logic [DegW-1:0] lo,
                                  input logic [DegW-1:0] hi);
    covers = ((lo <= hi) && (lo <= rot) && (rot <= hi)) ||
             ((lo >= hi) && ((lo <= rot) || (rot <= hi)));
  endfunction

endpackage

### design/angular_range_rw_lock_arbiter_unit.sv
// Channel   Direction  Payload (tdata low bit up)                           Side
// s_axis    in         op[2:0] proc_id[18:3] degree[27:19] half_width[35:28] slave
// m_axis    out        grant_proc_id[15:0] grant_is_write[16] status[18:17]
//                      grant_count[23:19]; tuser = kind; tlast = last        master
//
// One transaction is taken at a time. Without a scan it goes from the accepting idle
// cycle through decode, the exit queue and exit held states and the status result.
// A scan adds a pass over all slots to find the held type, then walks the waiters,
// skipping uncovered ones and emitting a grant notice per grant; a process exit first
// walks the waiting queue, removing its waiters, and then frees its held slots.
// Reset is asynchronous and clears rotation, slot flags and the queue count.
// A stalled master side holds the current result and the scan in place.
`include "angular_range_rw_lock_arbiter_unit_defines.svh"

module angular_range_rw_lock_arbiter_unit
  import arla_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // op, proc_id, degree, half_width, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // grant_proc_id, grant_is_write, status, grant_count
  output logic        m_axis_tuser,  // kind
  output logic        m_axis_tlast   // last
);

  ctrl_t ctrl;
  stat_t stat;
  logic  kind, giw, last;
  logic [15:0] gpid;
  logic [1:0]  st;
  logic [4:0]  gcnt;

  // Sequencer: owns the handshake and the order of the scan phases.
  arla_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .stat_i     (stat),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl)
  );

  // Slot table, waiting queue and result formatting.
  arla_dp u_dp (
    .clk_i,
    .rst_ni,
    .ctrl_i          (ctrl),
    .op_i            (s_axis_tdata[2:0]),
    .proc_id_i       (s_axis_tdata[18:3]),
    .degree_i        (s_axis_tdata[27:19]),
    .half_width_i    (s_axis_tdata[35:28]),
    .stat_o          (stat),
    .out_valid_o     (m_axis_tvalid),
    .kind_o          (kind),
    .grant_proc_id_o (gpid),
    .grant_is_write_o(giw),
    .status_o        (st),
    .grant_count_o   (gcnt),
    .last_o          (last)
  );

  assign m_axis_tdata = {gcnt, st, giw, gpid};
  assign m_axis_tuser = kind;
  assign m_axis_tlast = last;

  `ARLA_ASSERT_IMP(a_last_kind, clk_i, rst_ni, m_axis_tvalid, m_axis_tlast == m_axis_tuser,
    "last must mark the status result")
  `ARLA_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, s_axis_tready, !m_axis_tvalid,
    "input taken while a result is pending")
  `ARLA_ASSERT_IMP(a_status_count, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata[23:17] == 7'd0, "grant notice carries status fields")

endmodule

### design/arla_ctrl.sv
`include "angular_range_rw_lock_arbiter_unit_defines.svh"

module arla_ctrl
  import arla_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_EXIT_W;
      end
      S_EXIT_W: begin
        if (stat_i.exit_w_done) state_d = S_EXIT_H;
      end
      S_EXIT_H: begin
        if (stat_i.exit_h_done) state_d = stat_i.do_scan ? S_HELD : S_EMIT_STATUS;
      end
      S_HELD: begin
        if (stat_i.held_done) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (stat_i.wait_done) state_d = S_EMIT_STATUS;
        else if (stat_i.grant_now) state_d = S_EMIT_GRANT;
      end
      S_EMIT_GRANT: begin
        if (out_ready_i) state_d = S_WAIT;
      end
      S_EMIT_STATUS: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        ctrl_o.load = in_valid_i;
        ctrl_o.exit_w_clr = 1'b1;
        ctrl_o.held_clr = 1'b1;
      end
      S_DECODE:      ctrl_o.apply = 1'b1;
      S_EXIT_W:      ctrl_o.exit_w_step = 1'b1;
      S_EXIT_H:      ctrl_o.exit_h_step = 1'b1;
      S_HELD:        ctrl_o.held_step = 1'b1;
      S_WAIT:        ctrl_o.wait_step = 1'b1;
      S_EMIT_GRANT:  ctrl_o.out_grant = 1'b1;
      S_EMIT_STATUS: ctrl_o.out_status = 1'b1;
      default: ;
    endcase
  end

  `ARLA_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == S_IDLE,
    "input accepted outside idle")
  `ARLA_ASSERT_NEXT(a_load_decode, clk_i, rst_ni, ctrl_o.load, state_q == S_DECODE,
    "accepted transaction not decoded")
  `ARLA_ASSERT_NEXT(a_status_done, clk_i, rst_ni,
    (state_q == S_EMIT_STATUS) && out_ready_i, state_q == S_IDLE,
    "status result not followed by idle")

endmodule

### design/arla_dp.sv
module arla_dp
  import arla_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_t                  ctrl_i,
  input  logic [2:0]             op_i,
  input  logic [15:0]            proc_id_i,
  input  logic [DegW-1:0]        degree_i,
  input  logic [7:0]             half_width_i,
  output stat_t                  stat_o,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output logic [15:0]            grant_proc_id_o,
  output logic                   grant_is_write_o,
  output logic [1:0]             status_o,
  output logic [4:0]             grant_count_o,
  output logic                   last_o
);

  logic [2:0]      op_q;
  logic [15:0]     pid_q;
  logic [DegW-1:0] deg_q;
  logic [7:0]      hw_q;
  logic [DegW-1:0] rot_q;
  logic [Entries-1:0] valid_q, held_q;
  logic [15:0]     owner_q [Entries];
  logic [DegW-1:0] lower_q [Entries];
  logic [DegW-1:0] upper_q [Entries];
  logic [Entries-1:0] write_q;
  logic [SlotW-1:0] order_q [Entries];
  logic [CntW-1:0] wcnt_q;
  logic [CntW-1:0] idx_q;
  held_e           ht_q;
  logic            scan_q;
  logic [1:0]      st_q;
  logic [4:0]      gcnt_q;

  // Interval of the captured request.
  logic [DegW:0] lo_w, hi_w;
  logic [DegW-1:0] lo, hi;
  logic args_ok;
  always_comb begin
    lo_w = {1'b0, deg_q} - {2'b0, hw_q};
    if (lo_w[DegW]) lo_w = lo_w + (DegW+1)'(FullCircle);
    hi_w = {1'b0, deg_q} + {2'b0, hw_q};
    if (hi_w >= (DegW+1)'(FullCircle)) hi_w = hi_w - (DegW+1)'(FullCircle);
    lo = lo_w[DegW-1:0];
    hi = hi_w[DegW-1:0];
    args_ok = (deg_q < DegW'(FullCircle)) && (hw_q != 8'd0) &&
              ({1'b0, hw_q} < 9'(FullCircle / 2));
  end

  // Lowest free slot and unlock match.
  logic            free_any, match_any;
  logic [SlotW-1:0] free_idx, match_idx;
  always_comb begin
    free_any = 1'b0; free_idx = '0;
    match_any = 1'b0; match_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1; free_idx = SlotW'(i);
      end
      if (valid_q[i] && held_q[i] && owner_q[i] == pid_q && lower_q[i] == lo &&
          upper_q[i] == hi && write_q[i] == (op_q == OP_UNLOCK_WR)) begin
        match_any = 1'b1; match_idx = SlotW'(i);
      end
    end
  end

  logic [SlotW-1:0] idx_s, cur_slot;
  logic in_range, cur_cov, grant;
  held_e ht_next;
  assign idx_s    = idx_q[SlotW-1:0];
  assign in_range = idx_q < wcnt_q;
  assign cur_slot = order_q[idx_s];
  assign cur_cov  = covers(rot_q, lower_q[cur_slot], upper_q[cur_slot]);
  always_comb begin
    grant = 1'b0;
    ht_next = ht_q;
    if (ht_q == HT_EMPTY) begin
      grant = 1'b1;
      ht_next = write_q[cur_slot] ? HT_WRITE : HT_READ;
    end else if (ht_q == HT_READ && !write_q[cur_slot]) begin
      grant = 1'b1;
    end
  end

  logic exit_w_hit;
  assign exit_w_hit = in_range && owner_q[cur_slot] == pid_q;

  logic is_exit;
  assign is_exit = op_q == OP_EXIT;

  // A held slot freed in the last exit step must still start the scan.
  logic exit_h_hit;
  assign exit_h_hit = is_exit && valid_q[idx_s] && held_q[idx_s] &&
                      owner_q[idx_s] == pid_q;

  assign stat_o.do_scan     = scan_q || exit_h_hit;
  assign stat_o.exit_w_done = !is_exit || !in_range;
  assign stat_o.exit_h_done = !is_exit || (idx_q == CntW'(Entries - 1));
  assign stat_o.held_done   = idx_q == CntW'(Entries - 1);
  assign stat_o.wait_done   = !in_range || (cur_cov && !grant);
  assign stat_o.grant_now   = in_range && cur_cov && grant;

  logic [SlotW-1:0] g_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q   <= '0;
      valid_q <= '0;
      held_q  <= '0;
      wcnt_q  <= '0;
      idx_q   <= '0;
      ht_q    <= HT_EMPTY;
      scan_q  <= 1'b0;
      st_q    <= ST_OK;
      gcnt_q  <= '0;
    end else begin
      if (ctrl_i.load) begin
        gcnt_q <= '0;
        scan_q <= 1'b0;
        st_q   <= ST_OK;
      end
      if (ctrl_i.exit_w_clr || ctrl_i.held_clr) begin
        idx_q <= '0;
        ht_q  <= HT_EMPTY;
      end
      if (ctrl_i.apply) begin
        unique case (op_q)
          OP_SET_ROT: begin
            if (deg_q > DegW'(FullCircle)) st_q <= ST_BAD_ARG;
            else begin
              rot_q  <= deg_q;
              scan_q <= 1'b1;
            end
          end
          OP_LOCK_RD, OP_LOCK_WR: begin
            if (!args_ok) st_q <= ST_BAD_ARG;
            else if (!free_any || wcnt_q >= CntW'(Entries)) st_q <= ST_FULL;
            else begin
              valid_q[free_idx] <= 1'b1;
              held_q[free_idx]  <= 1'b0;
              owner_q[free_idx] <= pid_q;
              lower_q[free_idx] <= lo;
              upper_q[free_idx] <= hi;
              write_q[free_idx] <= op_q == OP_LOCK_WR;
              order_q[wcnt_q[SlotW-1:0]] <= free_idx;
              wcnt_q <= wcnt_q + 1'b1;
              scan_q <= 1'b1;
            end
          end
          OP_UNLOCK_RD, OP_UNLOCK_WR: begin
            if (!args_ok) st_q <= ST_BAD_ARG;
            else if (!match_any) st_q <= ST_NOT_FOUND;
            else begin
              valid_q[match_idx] <= 1'b0;
              held_q[match_idx]  <= 1'b0;
              scan_q <= 1'b1;
            end
          end
          OP_EXIT: ;
          default: st_q <= ST_BAD_ARG;
        endcase
      end
      // Exit: walk the waiting queue, removing entries of the process.
      if (ctrl_i.exit_w_step && is_exit) begin
        if (exit_w_hit) begin
          valid_q[cur_slot] <= 1'b0;
          for (int i = 0; i < Entries - 1; i++) begin
            if (CntW'(i) >= idx_q) order_q[i] <= order_q[i+1];
          end
          wcnt_q <= wcnt_q - 1'b1;
        end else if (in_range) begin
          idx_q <= idx_q + 1'b1;
        end else begin
          idx_q <= '0;
        end
      end
      // Exit: free held entries, one slot per cycle.
      if (ctrl_i.exit_h_step && is_exit) begin
        if (exit_h_hit) begin
          valid_q[idx_s] <= 1'b0;
          held_q[idx_s]  <= 1'b0;
          scan_q <= 1'b1;
        end
        idx_q <= (idx_q == CntW'(Entries - 1)) ? '0 : idx_q + 1'b1;
      end
      if (ctrl_i.exit_h_step && !is_exit) idx_q <= '0;
      // Strongest held type covering the rotation.
      if (ctrl_i.held_step) begin
        if (valid_q[idx_s] && held_q[idx_s] &&
            covers(rot_q, lower_q[idx_s], upper_q[idx_s])) begin
          if (write_q[idx_s]) ht_q <= HT_WRITE;
          else if (ht_q == HT_EMPTY) ht_q <= HT_READ;
        end
        idx_q <= (idx_q == CntW'(Entries - 1)) ? '0 : idx_q + 1'b1;
      end
      // Waiter scan.
      if (ctrl_i.wait_step && in_range) begin
        if (!cur_cov) idx_q <= idx_q + 1'b1;
        else if (grant) begin
          ht_q <= ht_next;
          held_q[cur_slot] <= 1'b1;
          g_slot_q <= cur_slot;
          for (int i = 0; i < Entries - 1; i++) begin
            if (CntW'(i) >= idx_q) order_q[i] <= order_q[i+1];
          end
          wcnt_q <= wcnt_q - 1'b1;
          gcnt_q <= gcnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= op_i;
      pid_q <= proc_id_i;
      deg_q <= degree_i;
      hw_q  <= half_width_i;
    end
  end

  assign out_valid_o      = ctrl_i.out_grant || ctrl_i.out_status;
  assign kind_o           = ctrl_i.out_status;
  assign grant_proc_id_o  = ctrl_i.out_grant ? owner_q[g_slot_q] : 16'd0;
  assign grant_is_write_o = ctrl_i.out_grant ? write_q[g_slot_q] : 1'b0;
  assign status_o         = ctrl_i.out_status ? st_q : ST_OK;
  assign grant_count_o    = ctrl_i.out_status ? gcnt_q : 5'd0;
  assign last_o           = ctrl_i.out_status;

endmodule
